// ===== sv/e2q_pkg.sv =====
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, widths, constants and the rounded fixed-point multiply for
// the Euler-angle to quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

   // Port widths
   localparam int ANGLE_BITS = 16;
   localparam int QUAT_BITS  = 16;

   // Internal Q2.30 datapath widths
   localparam int FX_W   = 33;   // signed sine, cosine, half-angle, series term
   localparam int MAG_W  = 32;   // magnitude of an FX_W operand
   localparam int PROD_W = 35;   // signed rounded product
   localparam int SUM_W  = 36;   // signed sum of two products

   // Series division by a constant: reciprocal multiply plus one correction
   localparam int P_W       = 34;
   localparam int REC_SHIFT = 34;
   localparam int REC_W     = 34;
   localparam int DIV_W     = 9;

   localparam int SERIES_TERMS = 10;

   localparam logic signed [FX_W-1:0] FX_ONE     = 33'sd1073741824;
   localparam logic signed [34:0]     FX_PI      = 35'sd3373259426;
   localparam logic signed [34:0]     FX_HALF_PI = 35'sd1686629713;

   localparam int ANGLE_SHIFT = 32 - ANGLE_BITS;
   localparam int QUAT_SHIFT  = 32 - QUAT_BITS;
   localparam logic signed [SUM_W-1:0] QUAT_BIAS = SUM_W'((64'd1 << QUAT_SHIFT) >> 1);
   localparam logic signed [SUM_W-1:0] QUAT_LIM  = SUM_W'(64'd1 << (QUAT_BITS - 2));

   // Pipeline depth: fold, square, three stages per series term, final sine
   localparam int SINCOS_LAT = 3 * SERIES_TERMS + 3;
   // Then first products, second products, sums, rounding
   localparam int TOTAL_LAT  = SINCOS_LAT + 4;

   typedef struct packed {
      logic signed [ANGLE_BITS-1:0] angle_x;
      logic signed [ANGLE_BITS-1:0] angle_y;
      logic signed [ANGLE_BITS-1:0] angle_z;
   } req_type;

   typedef struct packed {
      logic signed [QUAT_BITS-1:0] quat_part0;
      logic signed [QUAT_BITS-1:0] quat_part1;
      logic signed [QUAT_BITS-1:0] quat_part2;
      logic signed [QUAT_BITS-1:0] quat_part3;
   } rsp_type;

   // Magnitude of a signed operand
   function automatic logic [MAG_W-1:0] fx_mag(input logic signed [FX_W-1:0] a);
      logic signed [FX_W-1:0] n;
      n = (a < 0) ? -a : a;
      return n[MAG_W-1:0];
   endfunction

   // Q2.30 multiply, rounded half away from zero
   function automatic logic signed [PROD_W-1:0] fx_mul(input logic signed [FX_W-1:0] a,
                                                       input logic signed [FX_W-1:0] b);
      logic [2*MAG_W-1:0] p;
      logic [PROD_W-1:0]  m;
      logic               neg;
      neg = (a < 0) != (b < 0);
      p   = ((2*MAG_W)'(fx_mag(a)) * (2*MAG_W)'(fx_mag(b))) + (64'd1 << 29);
      m   = PROD_W'(p >> 30);
      return neg ? -$signed(m) : $signed(m);
   endfunction

endpackage

// ===== sv/e2q_horner_step.sv =====
// ----------------------------------------------------------------------------
// e2q_horner_step
// One series term: t_out = 1 - (x2 * t_in) / div, quotient truncated toward
// zero, over three register stages.
// ----------------------------------------------------------------------------
module e2q_horner_step
   import e2q_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic [MAG_W-1:0]       x2,
   input  logic signed [FX_W-1:0] t_in,
   input  logic [DIV_W-1:0]       div,
   input  logic [REC_W-1:0]       recip,
   output logic signed [FX_W-1:0] t_out
);

   logic [2*MAG_W-1:0]     prod1;
   logic [P_W-1:0]         pmag_in, pmag_ff, pmag2_ff;
   logic                   neg_ff, neg2_ff;
   logic [P_W+REC_W-1:0]   prod2;
   logic [P_W-1:0]         q0_in, q0_ff;
   logic [P_W-1:0]         qd, rem, quo;
   logic signed [FX_W-1:0] t_out_in, t_out_ff;

   // Stage 1: rounded product magnitude
   always_comb begin
      prod1   = ((2*MAG_W)'(x2) * (2*MAG_W)'(fx_mag(t_in))) + (64'd1 << 29);
      pmag_in = P_W'(prod1 >> 30);
   end

   // Stage 2: reciprocal estimate of the quotient
   always_comb begin
      prod2 = (P_W+REC_W)'(pmag_ff) * (P_W+REC_W)'(recip);
      q0_in = P_W'(prod2 >> REC_SHIFT);
   end

   // Stage 3: correct the estimate and subtract from one
   always_comb begin
      qd       = P_W'(q0_ff * P_W'(div));
      rem      = pmag2_ff - qd;
      quo      = (rem >= P_W'(div)) ? q0_ff + P_W'(1) : q0_ff;
      t_out_in = neg2_ff ? FX_ONE + FX_W'(quo) : FX_ONE - FX_W'(quo);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pmag_ff  <= pmag_in;
         neg_ff   <= t_in < 0;
         q0_ff    <= q0_in;
         pmag2_ff <= pmag_ff;
         neg2_ff  <= neg_ff;
         t_out_ff <= t_out_in;
      end
   end

   assign t_out = t_out_ff;

endmodule

// ===== sv/e2q_sincos.sv =====
// ----------------------------------------------------------------------------
// e2q_sincos
// Sine and cosine of half an input angle in Q2.30: fold into +-pi/2,
// square, evaluate both series term by term, apply the fold sign.
// ----------------------------------------------------------------------------
module e2q_sincos
   import e2q_pkg::*;
(
   input  logic                         clock,
   input  logic                         en,
   input  logic signed [ANGLE_BITS-1:0] angle,
   output logic signed [FX_W-1:0]       sin_val,
   output logic signed [FX_W-1:0]       cos_val
);

   localparam int X2_LEN = 3 * (SERIES_TERMS - 1) + 1;
   localparam int H_LEN  = 3 * SERIES_TERMS + 2;

   logic signed [34:0]     h_raw;
   logic signed [FX_W-1:0] h_fold;
   logic                   flip_in;
   logic signed [FX_W-1:0] h_line_ff [H_LEN];
   logic                   flip_line_ff [H_LEN];
   logic [MAG_W-1:0]       x2_line_ff [X2_LEN];
   logic signed [FX_W-1:0] sin_t [SERIES_TERMS+1];
   logic signed [FX_W-1:0] cos_t [SERIES_TERMS+1];
   logic signed [PROD_W-1:0] sin_prod;
   logic signed [FX_W-1:0] sin_in, cos_in, sin_ff, cos_ff;

   // Halve the angle into Q2.30 and fold into +-pi/2
   always_comb begin
      h_raw = 35'(angle) <<< ANGLE_SHIFT;
      if (h_raw > FX_HALF_PI) begin
         h_fold  = FX_W'(h_raw - FX_PI);
         flip_in = 1'b1;
      end else if (h_raw < -FX_HALF_PI) begin
         h_fold  = FX_W'(h_raw + FX_PI);
         flip_in = 1'b1;
      end else begin
         h_fold  = FX_W'(h_raw);
         flip_in = 1'b0;
      end
   end

   // Carry the folded angle, fold flag and square down the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         h_line_ff[0]    <= h_fold;
         flip_line_ff[0] <= flip_in;
         for (int i = 1; i < H_LEN; i++) begin
            h_line_ff[i]    <= h_line_ff[i-1];
            flip_line_ff[i] <= flip_line_ff[i-1];
         end
         x2_line_ff[0] <= MAG_W'(fx_mul(h_line_ff[0], h_line_ff[0]));
         for (int i = 1; i < X2_LEN; i++) begin
            x2_line_ff[i] <= x2_line_ff[i-1];
         end
      end
   end

   assign sin_t[0] = FX_ONE;
   assign cos_t[0] = FX_ONE;

   // Series terms, highest order first
   for (genvar j = 0; j < SERIES_TERMS; j++) begin : g_term
      localparam int      K     = SERIES_TERMS - j;
      localparam longint  SIN_D = 2 * K * (2 * K + 1);
      localparam longint  COS_D = (2 * K - 1) * (2 * K);
      localparam logic [REC_W-1:0] SIN_M = REC_W'((64'd1 << REC_SHIFT) / SIN_D);
      localparam logic [REC_W-1:0] COS_M = REC_W'((64'd1 << REC_SHIFT) / COS_D);

      e2q_horner_step u_sin_step (
         .clock (clock),
         .en    (en),
         .x2    (x2_line_ff[3*j]),
         .t_in  (sin_t[j]),
         .div   (DIV_W'(SIN_D)),
         .recip (SIN_M),
         .t_out (sin_t[j+1])
      );

      e2q_horner_step u_cos_step (
         .clock (clock),
         .en    (en),
         .x2    (x2_line_ff[3*j]),
         .t_in  (cos_t[j]),
         .div   (DIV_W'(COS_D)),
         .recip (COS_M),
         .t_out (cos_t[j+1])
      );
   end

   // Scale the sine series by the angle and apply the fold sign
   always_comb begin
      sin_prod = fx_mul(h_line_ff[H_LEN-1], sin_t[SERIES_TERMS]);
      sin_in   = flip_line_ff[H_LEN-1] ? FX_W'(-sin_prod) : FX_W'(sin_prod);
      cos_in   = flip_line_ff[H_LEN-1] ? -cos_t[SERIES_TERMS] : cos_t[SERIES_TERMS];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

// ===== sv/e2q_combine.sv =====
// ----------------------------------------------------------------------------
// e2q_combine
// Form the four quaternion components from the half-angle sines and
// cosines: two product stages, a sum stage and a round/saturate stage.
// ----------------------------------------------------------------------------
module e2q_combine
   import e2q_pkg::*;
(
   input  logic                   clock,
   input  logic                   en,
   input  logic signed [FX_W-1:0] sin_val [3],
   input  logic signed [FX_W-1:0] cos_val [3],
   output rsp_type                quat
);

   logic signed [FX_W-1:0]   pa_in [8], pb_in [8], pc_in [8];
   logic signed [FX_W-1:0]   pab_ff [8], pc_ff [8];
   logic signed [PROD_W-1:0] tr_ff [8];
   logic signed [SUM_W-1:0]  sum_ff [4];
   logic signed [QUAT_BITS-1:0] part_in [4], part_ff [4];

   // Operand selection for the eight triple products
   always_comb begin
      pa_in[0] = cos_val[0]; pb_in[0] = cos_val[1]; pc_in[0] = cos_val[2];
      pa_in[1] = sin_val[0]; pb_in[1] = sin_val[1]; pc_in[1] = sin_val[2];
      pa_in[2] = sin_val[0]; pb_in[2] = cos_val[1]; pc_in[2] = cos_val[2];
      pa_in[3] = sin_val[1]; pb_in[3] = sin_val[2]; pc_in[3] = cos_val[0];
      pa_in[4] = sin_val[1]; pb_in[4] = cos_val[0]; pc_in[4] = cos_val[2];
      pa_in[5] = sin_val[0]; pb_in[5] = sin_val[2]; pc_in[5] = cos_val[1];
      pa_in[6] = sin_val[0]; pb_in[6] = sin_val[1]; pc_in[6] = cos_val[2];
      pa_in[7] = sin_val[2]; pb_in[7] = cos_val[0]; pc_in[7] = cos_val[1];
   end

   // Round and saturate each sum to the output format
   always_comb begin
      logic signed [SUM_W-1:0] biased, shifted;
      for (int i = 0; i < 4; i++) begin
         biased  = sum_ff[i] + QUAT_BIAS;
         shifted = biased >>> QUAT_SHIFT;
         if (shifted > QUAT_LIM) begin
            shifted = QUAT_LIM;
         end else if (shifted < -QUAT_LIM) begin
            shifted = -QUAT_LIM;
         end
         part_in[i] = QUAT_BITS'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 8; k++) begin
            pab_ff[k] <= FX_W'(fx_mul(pa_in[k], pb_in[k]));
            pc_ff[k]  <= pc_in[k];
            tr_ff[k]  <= fx_mul(pab_ff[k], pc_ff[k]);
         end
         sum_ff[0] <= SUM_W'(tr_ff[0]) - SUM_W'(tr_ff[1]);
         sum_ff[1] <= SUM_W'(tr_ff[2]) + SUM_W'(tr_ff[3]);
         sum_ff[2] <= SUM_W'(tr_ff[4]) - SUM_W'(tr_ff[5]);
         sum_ff[3] <= SUM_W'(tr_ff[6]) + SUM_W'(tr_ff[7]);
         for (int i = 0; i < 4; i++) begin
            part_ff[i] <= part_in[i];
         end
      end
   end

   assign quat.quat_part0 = part_ff[0];
   assign quat.quat_part1 = part_ff[1];
   assign quat.quat_part2 = part_ff[2];
   assign quat.quat_part3 = part_ff[3];

endmodule

// ===== sv/euler_angles_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_core
// Euler angles (XYZ) to quaternion, fully pipelined fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries three angles in radians (signed Q2.13) on req_data with
//   req_valid / req_ready. Each request yields one response on rsp_data with
//   rsp_valid / rsp_ready: four quaternion components in signed Q1.14,
//   rounded to nearest and saturated to +-1.0.
//   The pipeline takes one request per cycle unless the output stalls.
//   Depth is set by the sine/cosine series: three stages for each of the
//   ten terms (product, reciprocal multiply, correction), plus fold,
//   square, final sine scale, two product stages, a sum and a rounding
//   stage.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; a stalled receiver freezes every stage, so
//   req_ready drops and nothing is lost or repeated.
//   Reset clears all valid bits; no state carries between requests.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_core
   import e2q_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                         en;
   logic [TOTAL_LAT-1:0]         valid_ff;
   logic signed [ANGLE_BITS-1:0] angles [3];
   logic signed [FX_W-1:0]       sin_val [3];
   logic signed [FX_W-1:0]       cos_val [3];

   // Advance when the output register is empty or being drained
   assign en        = !valid_ff[TOTAL_LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_ff[TOTAL_LAT-1];

   // Track valid requests through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   assign angles[0] = req_data.angle_x;
   assign angles[1] = req_data.angle_y;
   assign angles[2] = req_data.angle_z;

   for (genvar a = 0; a < 3; a++) begin : g_axis
      e2q_sincos u_sincos (
         .clock   (clock),
         .en      (en),
         .angle   (angles[a]),
         .sin_val (sin_val[a]),
         .cos_val (cos_val[a])
      );
   end

   e2q_combine u_combine (
      .clock   (clock),
      .en      (en),
      .sin_val (sin_val),
      .cos_val (cos_val),
      .quat    (rsp_data)
   );

endmodule

// ===== bench/euler_angles_to_quaternion_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_angles_to_quaternion_core_tb
// Drives angle triples through the quaternion pipeline under random burst
// and stall patterns and checks every quaternion against a bit-exact model.
// ----------------------------------------------------------------------------
module euler_angles_to_quaternion_core_tb
   import e2q_pkg::*;
();

   localparam int N_RANDOM = 800;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type angle_queue[$];
   rsp_type quat_queue[$];
   int      error_count = 0;
   bit      stim_done = 1'b0;

   euler_angles_to_quaternion_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // Q2.30 multiply, rounded half away from zero
   function automatic longint q30_mul(longint a, longint b);
      bit     neg;
      longint ma;
      longint mb;
      longint p;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p = (ma * mb + (64'sd1 << 29)) >>> 30;
      return neg ? -p : p;
   endfunction

   // Sine and cosine of a Q2.30 half-angle by folded Taylor series
   task automatic half_sin_cos(input longint h, output longint s, output longint c);
      longint pi_q;
      longint half_pi_q;
      longint x2;
      longint ts;
      longint tc;
      bit     flip;
      pi_q = 64'sd3373259426;
      half_pi_q = 64'sd1686629713;
      flip = 1'b0;
      if (h > half_pi_q) begin
         h = h - pi_q;
         flip = 1'b1;
      end else if (h < -half_pi_q) begin
         h = h + pi_q;
         flip = 1'b1;
      end
      x2 = q30_mul(h, h);
      ts = 64'sd1 << 30;
      tc = 64'sd1 << 30;
      for (int k = 10; k >= 1; k--) begin
         ts = (64'sd1 << 30) - q30_mul(x2, ts) / longint'((2*k) * (2*k + 1));
         tc = (64'sd1 << 30) - q30_mul(x2, tc) / longint'((2*k - 1) * (2*k));
      end
      ts = q30_mul(h, ts);
      s = flip ? -ts : ts;
      c = flip ? -tc : tc;
   endtask

   // Round Q2.30 to Q1.14, ties toward plus infinity, and saturate
   function automatic logic signed [QUAT_BITS-1:0] to_q14(longint v);
      longint r;
      longint lim;
      lim = 64'sd1 << (QUAT_BITS - 2);
      r = (v + (64'sd1 << (31 - QUAT_BITS))) >>> (32 - QUAT_BITS);
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return QUAT_BITS'(r);
   endfunction

   function automatic longint trip(longint a, longint b, longint c);
      return q30_mul(q30_mul(a, b), c);
   endfunction

   task automatic predict_quat(input req_type a, output rsp_type q);
      longint sx, cx, sy, cy, sz, cz;
      half_sin_cos(longint'(a.angle_x) <<< (32 - ANGLE_BITS), sx, cx);
      half_sin_cos(longint'(a.angle_y) <<< (32 - ANGLE_BITS), sy, cy);
      half_sin_cos(longint'(a.angle_z) <<< (32 - ANGLE_BITS), sz, cz);
      q.quat_part0 = to_q14(trip(cx, cy, cz) - trip(sx, sy, sz));
      q.quat_part1 = to_q14(trip(sx, cy, cz) + trip(sy, sz, cx));
      q.quat_part2 = to_q14(trip(sy, cx, cz) - trip(sx, sz, cy));
      q.quat_part3 = to_q14(trip(sx, sy, cz) + trip(sz, cx, cy));
   endtask

   function automatic logic signed [ANGLE_BITS-1:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return ANGLE_BITS'($urandom_range(0, 6) * 16'sd4096 - 16'sd12868);
         1: return ANGLE_BITS'($urandom_range(0, 64) - 32);
         2: return $urandom_range(0, 1) ? ANGLE_BITS'(16'sh7fff - $urandom_range(0, 15))
                                        : ANGLE_BITS'(16'sh8000 + $urandom_range(0, 15));
         default: return ANGLE_BITS'($urandom());
      endcase
   endfunction

   // Fill the queue of pending requests
   initial begin
      logic signed [ANGLE_BITS-1:0] corner[9];
      req_type a;
      corner = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                 16'sd12868, -16'sd12868, 16'sd25736, -16'sd25736};
      for (int i = 0; i < 9; i++) begin
         a.angle_x = corner[i];
         a.angle_y = corner[(i + 3) % 9];
         a.angle_z = corner[(i + 6) % 9];
         angle_queue.push_back(a);
      end
      for (int i = 0; i < 9; i++) begin
         a = '0;
         case (i % 3)
            0: a.angle_x = corner[i];
            1: a.angle_y = corner[i];
            default: a.angle_z = corner[i];
         endcase
         angle_queue.push_back(a);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         a.angle_x = rand_angle();
         a.angle_y = rand_angle();
         a.angle_z = rand_angle();
         angle_queue.push_back(a);
      end
   end

   // Driver: bursts with gaps; one pause until the pipeline drains
   int  burst_left = 0;
   int  gap_left = 0;
   int  sent = 0;
   bit  drain_pause = 1'b0;
   bit  drain_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rsp_type q;
            predict_quat(req_data, q);
            quat_queue.push_back(q);
            sent = sent + 1;
         end
         if (!(req_valid && !req_ready)) begin
            if (sent == 300 && !drain_done) begin
               drain_done = 1'b1;
               drain_pause = 1'b1;
            end
            if (drain_pause && quat_queue.size() == 0) begin
               drain_pause = 1'b0;
            end
            if (drain_pause) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left = gap_left - 1;
               req_valid <= 1'b0;
            end else if (angle_queue.size() != 0) begin
               req_data <= angle_queue.pop_front();
               req_valid <= 1'b1;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
               end
               burst_left = burst_left - 1;
               if (burst_left == 0) begin
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
               stim_done = 1'b1;
            end
         end
      end
   end

   // Receiver stall pattern, plus one long hold-off
   int hold_count = 0;
   int rx_cycle = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (rx_cycle == 150) begin
            hold_count = 120;
         end
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            rsp_ready <= 1'b0;
         end else if ((rx_cycle / 64) % 3 == 2) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   // Monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (quat_queue.size() == 0) begin
            $display("%0t: unexpected response %h", $time, rsp_data);
            error_count = error_count + 1;
         end else begin
            rsp_type q;
            q = quat_queue.pop_front();
            if (rsp_data.quat_part0 !== q.quat_part0) begin
               $display("%0t: quat_part0 expected %0d actual %0d",
                        $time, q.quat_part0, rsp_data.quat_part0);
               error_count = error_count + 1;
            end
            if (rsp_data.quat_part1 !== q.quat_part1) begin
               $display("%0t: quat_part1 expected %0d actual %0d",
                        $time, q.quat_part1, rsp_data.quat_part1);
               error_count = error_count + 1;
            end
            if (rsp_data.quat_part2 !== q.quat_part2) begin
               $display("%0t: quat_part2 expected %0d actual %0d",
                        $time, q.quat_part2, rsp_data.quat_part2);
               error_count = error_count + 1;
            end
            if (rsp_data.quat_part3 !== q.quat_part3) begin
               $display("%0t: quat_part3 expected %0d actual %0d",
                        $time, q.quat_part3, rsp_data.quat_part3);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Reset, then wait for the queues to drain
   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stim_done && quat_queue.size() == 0);
      repeat (TOTAL_LAT + 20) @(posedge clock);
      if (error_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Timeout
   initial begin
      #200000;
      $display("Mismatches found");
      $finish;
   end

endmodule
